FILE: rtl/core/tslf_pkg.sv
// Shared constants, codes and types of the three-segment line fit core.
// Depends on nothing; every other file of the core depends on it.
package tslf_pkg;

  localparam int MaxPoints = 256;
  localparam int AddrW     = 8;
  localparam int CntW      = 9;
  localparam int SampleW   = 16;
  localparam int MinW      = 7;
  localparam int TrimW     = 8;
  localparam int CfgW      = 8;
  localparam int CfgIdxW   = 1;
  localparam int BreakW    = 8;
  localparam int FitW      = 48;
  localparam int ErrW      = 64;

  // Prefix sum widths
  localparam int YW  = 25;
  localparam int XyW = 33;
  localparam int YyW = 41;
  localparam int XW  = 15;
  localparam int XxW = 23;

  // Shared arithmetic unit widths
  localparam int AccW     = 82;
  localparam int MbW      = 40;
  localparam int DivSteps = 82;
  localparam int DcntW    = 7;

  localparam logic [CfgIdxW-1:0] CfgMinSeg  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMaxTrim = 1'b1;

  localparam logic [FitW-1:0] FitPosMax = {1'b0, {(FitW-1){1'b1}}};
  localparam logic [FitW-1:0] FitNegMax = {1'b1, {(FitW-1){1'b0}}};

  typedef struct packed {
    logic [YW-1:0]  y;
    logic [XyW-1:0] xy;
    logic [YyW-1:0] yy;
    logic [XW-1:0]  x;
    logic [XxW-1:0] xx;
  } pfx_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_LD_XY,
    ST_LD_YY,
    ST_LD_XX,
    ST_LD_WR,
    ST_SETUP,
    ST_RD0,
    ST_RD1,
    ST_DIFF,
    ST_LOAD,
    ST_RUN,
    ST_DONE,
    ST_SEGEND,
    ST_SUM,
    ST_CMP,
    ST_OUT
  } st_t;

  // Micro-operations of one segment fit, in issue order
  typedef enum logic [3:0] {
    OP_CSXX,
    OP_SXSX,
    OP_CSXY,
    OP_SXSY,
    OP_SYSXX,
    OP_SXSXY,
    OP_CSYY,
    OP_SYSY,
    OP_T,
    OP_U,
    OP_CD,
    OP_D_SLOPE,
    OP_D_ICPT,
    OP_D_ERR
  } op_t;

endpackage

FILE: rtl/core/tslf_in_if.sv
// Input channel of the line fit core: valid/ready with one curve sample.
// Depends on tslf_pkg.
interface tslf_in_if;
  logic                           valid;
  logic                           ready;
  logic [tslf_pkg::SampleW-1:0]   sample;
  logic                           last;

  modport source(output valid, sample, last, input ready);
  modport sink(input valid, sample, last, output ready);
endinterface

FILE: rtl/core/tslf_out_if.sv
// Result channel of the line fit core: valid/ready with breakpoints and fits.
// Depends on tslf_pkg.
interface tslf_out_if;
  logic                                valid;
  logic                                ready;
  logic [tslf_pkg::BreakW-1:0]         first_break;
  logic [tslf_pkg::BreakW-1:0]         second_break;
  logic [tslf_pkg::ErrW-1:0]           total_error;
  logic signed [tslf_pkg::FitW-1:0]    head_slope;
  logic signed [tslf_pkg::FitW-1:0]    head_intercept;
  logic [tslf_pkg::ErrW-1:0]           head_error;
  logic signed [tslf_pkg::FitW-1:0]    middle_slope;
  logic signed [tslf_pkg::FitW-1:0]    middle_intercept;
  logic [tslf_pkg::ErrW-1:0]           middle_error;
  logic signed [tslf_pkg::FitW-1:0]    tail_slope;
  logic signed [tslf_pkg::FitW-1:0]    tail_intercept;
  logic [tslf_pkg::ErrW-1:0]           tail_error;

  modport source(output valid, first_break, second_break, total_error,
                 head_slope, head_intercept, head_error,
                 middle_slope, middle_intercept, middle_error,
                 tail_slope, tail_intercept, tail_error,
                 input ready);
  modport sink(input valid, first_break, second_break, total_error,
               head_slope, head_intercept, head_error,
               middle_slope, middle_intercept, middle_error,
               tail_slope, tail_intercept, tail_error,
               output ready);
endinterface

FILE: rtl/core/three_segment_linear_fit_core.sv
// A sample without the last mark passes LD_XY, LD_YY, LD_XX and LD_WR before the next is
// taken; once 256 are stored, further samples are not stored. The last sample starts a
// search over the allowed breakpoint pairs on one shared shift-add multiplier / restoring
// divider. A fit of two or more samples runs 11 products and 3 divisions; a one-sample
// segment skips the shared unit. A pair costs three fits plus SUM and CMP; one curve at
// a time. Reset: state, count, sums clear, registers take 5 and 20; stores do not clear.
module three_segment_linear_fit_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tslf_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [tslf_pkg::CfgW-1:0]      cfg_data,
  tslf_in_if.sink                        in_ch,
  tslf_out_if.source                     out_ch
);
  import tslf_pkg::*;

  st_t st_r, st_nxt;
  op_t op_r, op_nxt;

  logic [MinW-1:0]    min_seg_r;
  logic [TrimW-1:0]   max_trim_r;
  logic [CntW-1:0]    cnt_r;
  logic [SampleW-1:0] y_r;
  logic [AddrW-1:0]   x_r;
  logic               last_r;

  // Running prefix sums of the curve being loaded
  logic [YW-1:0]  acc_y_r;
  logic [XyW-1:0] acc_xy_r;
  logic [YyW-1:0] acc_yy_r;
  logic [XW-1:0]  acc_x_r;
  logic [XxW-1:0] acc_xx_r;

  pfx_t               pfx_mem [MaxPoints];
  logic [SampleW-1:0] smp_mem [MaxPoints];
  pfx_t               rd_pfx_r;
  logic [SampleW-1:0] rd_smp_r;
  logic [AddrW-1:0]   pfx_raddr;

  // Search bounds and loop counters
  logic [MinW-1:0]  m_r;
  logic [AddrW-1:0] b1max_r, floor2_r, b2max_r, n1_r;
  logic [AddrW-1:0] b1_r, b2_r;
  logic [1:0]       seg_r;

  // Segment statistics and intermediate terms
  logic [AddrW-1:0] fa, fe;
  logic [CntW-1:0]  fcnt_r;
  pfx_t             hi_r, lo_pfx;
  logic [YW-1:0]    sy_r;
  logic [XyW-1:0]   sxy_r;
  logic [YyW-1:0]   syy_r;
  logic [XW-1:0]    sx_r;
  logic [XxW-1:0]   sxx_r;
  logic [31:0]      den_r;
  logic             nneg_r, ineg_r, eneg_r;
  logic [39:0]      nmag_r;
  logic [47:0]      imag_r;
  logic [48:0]      syyc_r;
  logic [AccW-1:0]  pa_r;
  logic [79:0]      ediff_r;
  logic [39:0]      cd_r;

  // Shared multiply / divide unit
  logic [AccW-1:0]  acc_r, ma_r;
  logic [MbW-1:0]   mb_r, rem_r;
  logic [DcntW-1:0] dcnt_r;
  logic [MbW:0]     rem_sh;
  logic             div_ge, op_div, rnd;
  logic [AccW-1:0]  ld_acc, ld_ma;
  logic [MbW-1:0]   ld_mb;

  // Fits of the current pair and the best pair
  logic [FitW-1:0]   cur_slope_r [3];
  logic [FitW-1:0]   cur_icpt_r  [3];
  logic [ErrW-1:0]   cur_err_r   [3];
  logic [FitW-1:0]   best_slope_r [3];
  logic [FitW-1:0]   best_icpt_r  [3];
  logic [ErrW-1:0]   best_err_r   [3];
  logic [ErrW-1:0]   best_tot_r, sum01_r;
  logic [BreakW-1:0] best_b1_r, best_b2_r;

  logic in_fire, out_fire;
  logic [31:0] lm;
  logic [15:0] lm_a, lm_b;

  logic [MinW-1:0] m_eff;
  logic [9:0] n10, m10, tr10, thr, t1, b1max_c, lim, fl_c, b2max_c;
  logic srch_ok, pair_more;

  logic [AccW-1:0] sub_pa, sub_ap;
  logic            pa_lt;
  logic [FitW-1:0] qmag, fit_q;
  logic            qbig, qsgn;
  logic [ErrW-1:0] err_q;
  logic            err_ovf;
  logic [ErrW:0]   sum_a, sum_b;
  logic [ErrW-1:0] tot;

  function automatic logic [AddrW-1:0] b2_floor(input logic [AddrW-1:0] b1v,
                                                input logic [MinW-1:0] mv,
                                                input logic [AddrW-1:0] fl);
    logic [AddrW:0] t;
    t = (AddrW+1)'(b1v) + (AddrW+1)'(mv) - (AddrW+1)'(1);
    return (t > (AddrW+1)'(fl)) ? t[AddrW-1:0] : fl;
  endfunction

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_fire     = out_ch.valid && out_ch.ready;
  assign in_ch.ready  = (st_r == ST_IDLE);
  assign out_ch.valid = (st_r == ST_OUT);

  // Load-path product: x*y, y*y, x*x in turn
  always_comb begin
    lm_a = y_r;
    lm_b = 16'(x_r);
    case (st_r)
      ST_LD_YY: lm_b = y_r;
      ST_LD_XX: lm_a = 16'(x_r);
      default:  lm_b = 16'(x_r);
    endcase
  end
  assign lm = lm_a * lm_b;

  // Search bounds from count and registers
  always_comb begin
    m_eff   = (min_seg_r == '0) ? MinW'(1) : min_seg_r;
    n10     = 10'(cnt_r);
    m10     = 10'(m_eff);
    tr10    = 10'(max_trim_r);
    thr     = (m10 << 1) + m10 + 10'd1;
    t1      = n10 - (m10 << 1) - 10'd1;
    b1max_c = (t1 < tr10) ? t1 : tr10;
    lim     = (n10 - 10'd1 > tr10) ? (n10 - 10'd1 - tr10) : 10'd0;
    fl_c    = (m10 - 10'd1 > lim) ? (m10 - 10'd1) : lim;
    b2max_c = n10 - m10 - 10'd1;
    srch_ok = (n10 >= thr) && (b1max_c >= m10) && (fl_c <= b2max_c);
  end

  assign pair_more = (b2_r < b2max_r) || (b1_r < b1max_r);

  // Segment bounds
  always_comb begin
    unique case (seg_r)
      2'd0: begin
        fa = '0;
        fe = b1_r - AddrW'(1);
      end
      2'd1: begin
        fa = b1_r;
        fe = b2_r;
      end
      default: begin
        fa = b2_r + AddrW'(1);
        fe = n1_r;
      end
    endcase
  end

  assign pfx_raddr = (st_r == ST_RD0) ? fe : (fa - AddrW'(1));
  assign lo_pfx    = (fa == '0) ? '0 : rd_pfx_r;

  // Shared unit helpers
  assign op_div = (op_r == OP_D_SLOPE) || (op_r == OP_D_ICPT) || (op_r == OP_D_ERR);
  assign rem_sh = {rem_r, acc_r[AccW-1]};
  assign div_ge = rem_sh >= {1'b0, mb_r};
  assign rnd    = {rem_r, 1'b0} >= {1'b0, mb_r};
  assign sub_pa = pa_r - acc_r;
  assign sub_ap = acc_r - pa_r;
  assign pa_lt  = pa_r < acc_r;

  // Round, saturate and sign the fit quotients
  always_comb begin
    qbig  = |acc_r[AccW-1:FitW-1];
    qmag  = {1'b0, acc_r[FitW-2:0]} + FitW'(rnd);
    qsgn  = (op_r == OP_D_SLOPE) ? nneg_r : ineg_r;
    if (qbig) begin
      fit_q = qsgn ? FitNegMax : FitPosMax;
    end else if (qsgn) begin
      fit_q = ~qmag + FitW'(1);
    end else begin
      fit_q = qmag[FitW-1] ? FitPosMax : qmag;
    end
    err_ovf = (|acc_r[AccW-1:ErrW]) || (rnd && (&acc_r[ErrW-1:0]));
    err_q   = err_ovf ? '1 : (acc_r[ErrW-1:0] + ErrW'(rnd));
  end

  // Saturating error totals
  assign sum_a = {1'b0, cur_err_r[0]} + {1'b0, cur_err_r[1]};
  assign sum_b = {1'b0, sum01_r} + {1'b0, cur_err_r[2]};
  assign tot   = sum_b[ErrW] ? '1 : sum_b[ErrW-1:0];

  // Operands of the shared unit for the current micro-operation
  always_comb begin
    ld_acc = '0;
    ld_ma  = '0;
    ld_mb  = '0;
    case (op_r)
      OP_CSXX: begin
        ld_ma = AccW'(sxx_r);
        ld_mb = MbW'(fcnt_r);
      end
      OP_SXSX: begin
        ld_ma = AccW'(sx_r);
        ld_mb = MbW'(sx_r);
      end
      OP_CSXY: begin
        ld_ma = AccW'(sxy_r);
        ld_mb = MbW'(fcnt_r);
      end
      OP_SXSY: begin
        ld_ma = AccW'(sy_r);
        ld_mb = MbW'(sx_r);
      end
      OP_SYSXX: begin
        ld_ma = AccW'(sxx_r);
        ld_mb = MbW'(sy_r);
      end
      OP_SXSXY: begin
        ld_ma = AccW'(sxy_r);
        ld_mb = MbW'(sx_r);
      end
      OP_CSYY: begin
        ld_ma = AccW'(syy_r);
        ld_mb = MbW'(fcnt_r);
      end
      OP_SYSY: begin
        ld_ma = AccW'(sy_r);
        ld_mb = MbW'(sy_r);
      end
      OP_T: begin
        ld_ma = AccW'(syyc_r);
        ld_mb = MbW'(den_r);
      end
      OP_U: begin
        ld_ma = AccW'(nmag_r);
        ld_mb = nmag_r;
      end
      OP_CD: begin
        ld_ma = AccW'(den_r);
        ld_mb = MbW'(fcnt_r);
      end
      OP_D_SLOPE: begin
        ld_acc = AccW'({nmag_r, 17'b0});
        ld_mb  = MbW'(den_r);
      end
      OP_D_ICPT: begin
        ld_acc = AccW'({imag_r, 17'b0});
        ld_mb  = MbW'(den_r);
      end
      default: begin
        ld_acc = AccW'({ediff_r, 2'b0});
        ld_mb  = cd_r;
      end
    endcase
  end

  // Next state
  always_comb begin
    st_nxt = st_r;
    op_nxt = op_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (!cnt_r[CntW-1]) st_nxt = ST_LD_XY;
          else if (in_ch.last) st_nxt = ST_SETUP;
        end
      end
      ST_LD_XY:  st_nxt = ST_LD_YY;
      ST_LD_YY:  st_nxt = ST_LD_XX;
      ST_LD_XX:  st_nxt = ST_LD_WR;
      ST_LD_WR:  st_nxt = last_r ? ST_SETUP : ST_IDLE;
      ST_SETUP:  st_nxt = srch_ok ? ST_RD0 : ST_OUT;
      ST_RD0:    st_nxt = ST_RD1;
      ST_RD1:    st_nxt = ST_DIFF;
      ST_DIFF: begin
        if (fa == fe) begin
          st_nxt = ST_SEGEND;
        end else begin
          op_nxt = OP_CSXX;
          st_nxt = ST_LOAD;
        end
      end
      ST_LOAD:   st_nxt = ST_RUN;
      ST_RUN: begin
        if (op_div ? (dcnt_r == DcntW'(1)) : (mb_r == '0)) st_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (op_r == OP_D_ERR) begin
          st_nxt = ST_SEGEND;
        end else begin
          op_nxt = op_t'(op_r + 4'd1);
          st_nxt = ST_LOAD;
        end
      end
      ST_SEGEND: st_nxt = (seg_r == 2'd2) ? ST_SUM : ST_RD0;
      ST_SUM:    st_nxt = ST_CMP;
      ST_CMP:    st_nxt = pair_more ? ST_RD0 : ST_OUT;
      ST_OUT: begin
        if (out_ch.ready) st_nxt = ST_IDLE;
      end
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // State, registers, count and running sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      op_r       <= OP_CSXX;
      min_seg_r  <= MinW'(5);
      max_trim_r <= TrimW'(20);
      cnt_r      <= '0;
      acc_y_r    <= '0;
      acc_xy_r   <= '0;
      acc_yy_r   <= '0;
      acc_x_r    <= '0;
      acc_xx_r   <= '0;
      seg_r      <= '0;
    end else begin
      st_r <= st_nxt;
      op_r <= op_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CfgMinSeg:  min_seg_r  <= cfg_data[MinW-1:0];
          CfgMaxTrim: max_trim_r <= cfg_data[TrimW-1:0];
        endcase
      end
      case (st_r)
        ST_LD_XY: acc_xy_r <= acc_xy_r + XyW'(lm);
        ST_LD_YY: acc_yy_r <= acc_yy_r + YyW'(lm);
        ST_LD_XX: begin
          acc_xx_r <= acc_xx_r + XxW'(lm);
          acc_x_r  <= acc_x_r + XW'(x_r);
          acc_y_r  <= acc_y_r + YW'(y_r);
        end
        ST_LD_WR: cnt_r <= cnt_r + CntW'(1);
        ST_SETUP: seg_r <= '0;
        ST_SEGEND: begin
          if (seg_r != 2'd2) seg_r <= seg_r + 2'd1;
        end
        ST_CMP: seg_r <= '0;
        ST_OUT: begin
          if (out_fire) begin
            cnt_r    <= '0;
            acc_y_r  <= '0;
            acc_xy_r <= '0;
            acc_yy_r <= '0;
            acc_x_r  <= '0;
            acc_xx_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Sample and prefix stores
  always_ff @(posedge clk) begin
    if (st_r == ST_LD_WR) begin
      pfx_mem[x_r] <= '{y: acc_y_r, xy: acc_xy_r, yy: acc_yy_r, x: acc_x_r, xx: acc_xx_r};
      smp_mem[x_r] <= y_r;
    end
    rd_pfx_r <= pfx_mem[pfx_raddr];
    rd_smp_r <= smp_mem[fa];
  end

  // Datapath: capture, search loop, shared unit, fit results
  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          y_r    <= in_ch.sample;
          last_r <= in_ch.last;
          x_r    <= cnt_r[AddrW-1:0];
        end
      end
      ST_SETUP: begin
        m_r        <= m_eff;
        b1max_r    <= b1max_c[AddrW-1:0];
        floor2_r   <= fl_c[AddrW-1:0];
        b2max_r    <= b2max_c[AddrW-1:0];
        n1_r       <= AddrW'(cnt_r - CntW'(1));
        b1_r       <= AddrW'(m_eff);
        b2_r       <= b2_floor(AddrW'(m_eff), m_eff, fl_c[AddrW-1:0]);
        best_tot_r <= '1;
        best_b1_r  <= '0;
        best_b2_r  <= AddrW'(cnt_r - CntW'(1));
        for (int k = 0; k < 3; k++) begin
          best_slope_r[k] <= '0;
          best_icpt_r[k]  <= '0;
          best_err_r[k]   <= '0;
        end
      end
      ST_RD1: hi_r <= rd_pfx_r;
      ST_DIFF: begin
        fcnt_r <= CntW'(fe) - CntW'(fa) + CntW'(1);
        sy_r   <= hi_r.y - lo_pfx.y;
        sxy_r  <= hi_r.xy - lo_pfx.xy;
        syy_r  <= hi_r.yy - lo_pfx.yy;
        sx_r   <= hi_r.x - lo_pfx.x;
        sxx_r  <= hi_r.xx - lo_pfx.xx;
        if (fa == fe) begin
          cur_slope_r[seg_r] <= '0;
          cur_icpt_r[seg_r]  <= FitW'({rd_smp_r, 17'b0});
          cur_err_r[seg_r]   <= '0;
        end
      end
      ST_LOAD: begin
        acc_r  <= ld_acc;
        rem_r  <= '0;
        dcnt_r <= DcntW'(DivSteps);
        ma_r   <= ld_ma;
        mb_r   <= ld_mb;
      end
      ST_RUN: begin
        if (op_div) begin
          // Restoring division, one quotient bit per cycle
          rem_r  <= div_ge ? MbW'(rem_sh - {1'b0, mb_r}) : rem_sh[MbW-1:0];
          acc_r  <= {acc_r[AccW-2:0], div_ge};
          dcnt_r <= dcnt_r - DcntW'(1);
        end else if (mb_r != '0) begin
          // Shift-add multiply, one multiplier bit per cycle
          if (mb_r[0]) acc_r <= acc_r + ma_r;
          ma_r <= ma_r << 1;
          mb_r <= mb_r >> 1;
        end
      end
      ST_DONE: begin
        case (op_r)
          OP_SXSX: den_r <= 32'(sub_pa);
          OP_SXSY: begin
            nneg_r <= pa_lt;
            nmag_r <= 40'(pa_lt ? sub_ap : sub_pa);
          end
          OP_SXSXY: begin
            ineg_r <= pa_lt;
            imag_r <= 48'(pa_lt ? sub_ap : sub_pa);
          end
          OP_SYSY: syyc_r <= 49'(sub_pa);
          OP_U: begin
            eneg_r  <= pa_lt;
            ediff_r <= 80'(sub_pa);
          end
          OP_CD:      cd_r <= 40'(acc_r);
          OP_D_SLOPE: cur_slope_r[seg_r] <= fit_q;
          OP_D_ICPT:  cur_icpt_r[seg_r] <= fit_q;
          OP_D_ERR:   cur_err_r[seg_r] <= eneg_r ? '0 : err_q;
          default:    pa_r <= acc_r;
        endcase
      end
      ST_SUM: sum01_r <= sum_a[ErrW] ? '1 : sum_a[ErrW-1:0];
      ST_CMP: begin
        // Keep the first pair with the smallest total
        if (tot < best_tot_r) begin
          best_tot_r <= tot;
          best_b1_r  <= b1_r;
          best_b2_r  <= b2_r;
          for (int k = 0; k < 3; k++) begin
            best_slope_r[k] <= cur_slope_r[k];
            best_icpt_r[k]  <= cur_icpt_r[k];
            best_err_r[k]   <= cur_err_r[k];
          end
        end
        // Advance b2, then b1
        if (b2_r < b2max_r) begin
          b2_r <= b2_r + AddrW'(1);
        end else if (b1_r < b1max_r) begin
          b1_r <= b1_r + AddrW'(1);
          b2_r <= b2_floor(b1_r + AddrW'(1), m_r, floor2_r);
        end
      end
      default: ;
    endcase
  end

  // Result payload
  assign out_ch.first_break      = best_b1_r;
  assign out_ch.second_break     = best_b2_r;
  assign out_ch.total_error      = best_tot_r;
  assign out_ch.head_slope       = best_slope_r[0];
  assign out_ch.head_intercept   = best_icpt_r[0];
  assign out_ch.head_error       = best_err_r[0];
  assign out_ch.middle_slope     = best_slope_r[1];
  assign out_ch.middle_intercept = best_icpt_r[1];
  assign out_ch.middle_error     = best_err_r[1];
  assign out_ch.tail_slope       = best_slope_r[2];
  assign out_ch.tail_intercept   = best_icpt_r[2];
  assign out_ch.tail_error       = best_err_r[2];

  // Checks
  a_side_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input taken while a result waits");

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MaxPoints))
    else $error("sample count beyond store depth");

  a_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire |=> (cnt_r == '0))
    else $error("curve not emptied after result transfer");

  a_div_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RUN && op_div) |-> (mb_r != '0))
    else $error("division by zero in shared unit");

  a_pair_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_CMP) |-> ((b1_r >= AddrW'(m_r)) &&
      ((AddrW+1)'(b2_r) + (AddrW+1)'(1) >= (AddrW+1)'(b1_r) + (AddrW+1)'(m_r))))
    else $error("breakpoint pair violates minimum segment length");

endmodule

FILE: test/tb_top.sv
// Self-checking bench for three_segment_linear_fit_core: loads curves, predicts each fit.
// Depends on tslf_pkg, tslf_in_if, tslf_out_if and the core RTL.
module tb_top;
  import tslf_pkg::*;

  typedef struct packed {
    logic [FitW-1:0] slope;
    logic [FitW-1:0] icpt;
    logic [ErrW-1:0] err;
  } line_fit_t;

  typedef struct packed {
    logic [BreakW-1:0] b1;
    logic [BreakW-1:0] b2;
    logic [ErrW-1:0]   total;
    line_fit_t         head;
    line_fit_t         mid;
    line_fit_t         tail;
  } fit_result_t;

  typedef struct packed {
    logic [SampleW-1:0] s;
    bit                 last;
    bit                 typed;
    logic [BreakW-1:0]  b2;
  } dir_row_t;

  localparam int IdleLimit = 200000;
  localparam int ItemTarget = 1600;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = CfgMinSeg;
  logic [CfgW-1:0] cfg_data = '0;

  tslf_in_if  in_ch();
  tslf_out_if out_ch();

  three_segment_linear_fit_core u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state
  logic [SampleW-1:0] curve_mem [MaxPoints];
  int          curve_len = 0;
  logic [MinW-1:0]  min_seg = 7'd5;
  logic [TrimW-1:0] trim_lim = 8'd20;
  fit_result_t fits_pending [$];
  int          failures = 0;
  int          items_sent = 0;
  bit          no_idle = 1'b0;
  int          idle_cycles = 0;

  // Piecewise curve shape
  int shape_kind, brk_a, brk_b, lvl [3], slp [3], noise_amp;

  function automatic logic [47:0] pack_fit(bit neg, logic [191:0] mag);
    if (neg) return (mag >= 192'h8000_0000_0000) ? FitNegMax : 48'(-mag);
    return (mag > 192'h7FFF_FFFF_FFFF) ? FitPosMax : mag[47:0];
  endfunction

  // round(mag * 2^17 / d) with halves away from zero; huge values flag as 2^47
  function automatic logic [191:0] scale_q17(logic [191:0] mag, logic [191:0] d);
    logic [191:0] q, r;
    if (mag / d >= 192'h4000_0000) return 192'h8000_0000_0000;
    q = (mag << 17) / d;
    r = (mag << 17) % d;
    if (2 * r >= d) q = q + 1;
    return q;
  endfunction

  function automatic line_fit_t fit_segment(int a, int e);
    line_fit_t f;
    logic [191:0] cnt, sy, sxy, syy, sx, sxx, y, den, p, q, nmag, imag, syyc, t, u, num, dv;
    logic [191:0] qq, rr;
    bit nneg, ineg;
    f = '0;
    cnt = e - a + 1;
    if (cnt < 2) begin
      f.icpt = 48'(curve_mem[a]) << 17;
      return f;
    end
    sy = 0; sxy = 0; syy = 0; sx = 0; sxx = 0;
    for (int i = a; i <= e; i++) begin
      y = curve_mem[i];
      sy += y;
      sxy += 192'(i) * y;
      syy += y * y;
      sx += 192'(i);
      sxx += 192'(i) * 192'(i);
    end
    den = cnt * sxx - sx * sx;
    p = cnt * sxy; q = sx * sy;
    nneg = p < q; nmag = nneg ? q - p : p - q;
    f.slope = pack_fit(nneg, scale_q17(nmag, den));
    p = sy * sxx; q = sx * sxy;
    ineg = p < q; imag = ineg ? q - p : p - q;
    f.icpt = pack_fit(ineg, scale_q17(imag, den));
    syyc = cnt * syy - sy * sy;
    t = den * syyc;
    u = nmag * nmag;
    if (t < u) return f;
    num = (t - u) << 2;
    dv = cnt * den;
    qq = num / dv;
    rr = num % dv;
    if (2 * rr >= dv) qq = qq + 1;
    f.err = (qq > 192'hFFFF_FFFF_FFFF_FFFF) ? '1 : qq[63:0];
    return f;
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // Search the allowed breakpoint pairs of the stored curve
  function automatic fit_result_t search_breaks();
    fit_result_t r, cur;
    int n, m, tr, b1max, lim, floor2, b2max, b2min;
    n = curve_len;
    m = (min_seg == 0) ? 1 : int'(min_seg);
    tr = trim_lim;
    r = '0;
    r.total = '1;
    r.b2 = (n > 0) ? BreakW'(n - 1) : '0;
    if (n >= 3 * m + 1) begin
      b1max = (n - 2 * m - 1 < tr) ? n - 2 * m - 1 : tr;
      lim = (n - 1 > tr) ? n - 1 - tr : 0;
      floor2 = (m - 1 > lim) ? m - 1 : lim;
      b2max = n - m - 1;
      if (b1max >= m && floor2 <= b2max) begin
        for (int b1 = m; b1 <= b1max; b1++) begin
          b2min = (b1 + m - 1 > floor2) ? b1 + m - 1 : floor2;
          for (int b2 = b2min; b2 <= b2max; b2++) begin
            cur.b1 = BreakW'(b1);
            cur.b2 = BreakW'(b2);
            cur.head = fit_segment(0, b1 - 1);
            cur.mid = fit_segment(b1, b2);
            cur.tail = fit_segment(b2 + 1, n - 1);
            cur.total = add_sat(add_sat(cur.head.err, cur.mid.err), cur.tail.err);
            if (cur.total < r.total) r = cur;
          end
        end
      end
    end
    return r;
  endfunction

  // Advance the predictor by one accepted sample
  task automatic take_sample(logic [SampleW-1:0] s, bit last, bit typed, logic [7:0] b2);
    fit_result_t r;
    if (curve_len < MaxPoints) begin
      curve_mem[curve_len] = s;
      curve_len++;
    end
    if (!last) return;
    if (typed) begin
      r = '0;
      r.b2 = b2;
      r.total = '1;
    end else begin
      r = search_breaks();
    end
    fits_pending.insert(fits_pending.size(), r);
    curve_len = 0;
  endtask

  task automatic send_sample(logic [SampleW-1:0] s, bit last, bit typed, logic [7:0] b2);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample <= s;
    in_ch.last <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    take_sample(s, last, typed, b2);
    items_sent++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgMinSeg) min_seg = val[MinW-1:0];
    else trim_lim = val;
  endtask

  // Hold the sender until every fit has come out, then let the core settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (fits_pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [SampleW-1:0] gen_sample(int idx);
    int v, seg;
    case (shape_kind)
      0: return SampleW'($urandom);
      2: return SampleW'(lvl[0]);
      3: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: begin
        seg = (idx < brk_a) ? 0 : (idx <= brk_b) ? 1 : 2;
        v = lvl[seg] + slp[seg] * idx;
        if (noise_amp > 0) v += int'($urandom_range(0, 2 * noise_amp)) - noise_amp;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return SampleW'(v);
      end
    endcase
  endfunction

  task automatic send_curve(int len, int stored_hint);
    shape_kind = $urandom_range(0, 5);
    if (shape_kind > 3) shape_kind = 1;
    brk_a = $urandom_range(1, stored_hint > 2 ? stored_hint / 2 : 1);
    brk_b = brk_a + $urandom_range(0, stored_hint > 2 ? stored_hint / 2 : 1);
    for (int k = 0; k < 3; k++) begin
      lvl[k] = $urandom_range(0, 65535);
      slp[k] = int'($urandom_range(0, 4000)) - 2000;
    end
    noise_amp = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 3000);
    for (int i = 0; i < len; i++)
      send_sample(gen_sample(i), i == len - 1, 1'b0, 8'd0);
  endtask

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      failures++;
    end
  endfunction

  // Result side: random stalls, compare each transfer, watch for a hang
  int stall_left = 0;
  always @(posedge clk) begin
    fit_result_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (fits_pending.size() == 0) begin
          $error("result transfer with no fit pending");
          failures++;
        end else begin
          e = fits_pending.pop_front();
          check_field("first_break", e.b1, out_ch.first_break);
          check_field("second_break", e.b2, out_ch.second_break);
          check_field("total_error", e.total, out_ch.total_error);
          check_field("head_slope", e.head.slope, $unsigned(out_ch.head_slope));
          check_field("head_intercept", e.head.icpt, $unsigned(out_ch.head_intercept));
          check_field("head_error", e.head.err, out_ch.head_error);
          check_field("middle_slope", e.mid.slope, $unsigned(out_ch.middle_slope));
          check_field("middle_intercept", e.mid.icpt, $unsigned(out_ch.middle_intercept));
          check_field("middle_error", e.mid.err, out_ch.middle_error);
          check_field("tail_slope", e.tail.slope, $unsigned(out_ch.tail_slope));
          check_field("tail_intercept", e.tail.icpt, $unsigned(out_ch.tail_intercept));
          check_field("tail_error", e.tail.err, out_ch.tail_error);
        end
      end
      if (!no_idle && stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 16);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Directed curves under reset settings: lone sample, short curve, extreme zigzag
  dir_row_t dir_rows [20] = '{
    '{16'h0000, 1'b1, 1'b1, 8'd0},
    '{16'hFFFF, 1'b0, 1'b0, 8'd0}, '{16'h0000, 1'b0, 1'b0, 8'd0},
    '{16'hFFFF, 1'b1, 1'b1, 8'd2},
    '{16'hFFFF, 1'b0, 1'b0, 8'd0}, '{16'h0000, 1'b0, 1'b0, 8'd0},
    '{16'hFFFF, 1'b0, 1'b0, 8'd0}, '{16'h0000, 1'b0, 1'b0, 8'd0},
    '{16'hFFFF, 1'b0, 1'b0, 8'd0}, '{16'hFFFF, 1'b0, 1'b0, 8'd0},
    '{16'hFFFF, 1'b0, 1'b0, 8'd0}, '{16'h0000, 1'b0, 1'b0, 8'd0},
    '{16'h0000, 1'b0, 1'b0, 8'd0}, '{16'h0000, 1'b0, 1'b0, 8'd0},
    '{16'h8000, 1'b0, 1'b0, 8'd0}, '{16'h7FFF, 1'b0, 1'b0, 8'd0},
    '{16'h0001, 1'b0, 1'b0, 8'd0}, '{16'hFFFE, 1'b0, 1'b0, 8'd0},
    '{16'h5555, 1'b0, 1'b0, 8'd0}, '{16'hAAAA, 1'b1, 1'b0, 8'd0}
  };

  initial begin
    int m, phase, len, curves;
    in_ch.valid <= 1'b0;
    in_ch.sample <= '0;
    in_ch.last <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_sample(dir_rows[i].s, dir_rows[i].last, dir_rows[i].typed, dir_rows[i].b2);
    drain();

    phase = 0;
    while (items_sent < ItemTarget) begin
      if (items_sent > ItemTarget - 250) no_idle = 1'b1;
      case (phase)
        0: begin
          // zero minimum acts as one; zero trim leaves no pair
          write_reg(CfgMinSeg, 8'h80);
          write_reg(CfgMaxTrim, 8'h00);
          send_curve(1, 1);
          send_curve(12, 12);
        end
        1: begin
          write_reg(CfgMinSeg, 8'h7F);
          write_reg(CfgMaxTrim, 8'h0F);
          send_curve(40, 40);
        end
        2: begin
          // minimum of 85 and largest trim: full store, one short and an overfull curve
          write_reg(CfgMinSeg, 8'd85);
          write_reg(CfgMaxTrim, 8'hFF);
          send_curve(256, 256);
          send_curve(255, 255);
          send_curve(300, 256);
        end
        default: begin
          m = $urandom_range(1, 6);
          write_reg(CfgMinSeg, {1'($urandom), 7'(m)});
          write_reg(CfgMaxTrim, 8'(m + $urandom_range(0, 1)));
          curves = $urandom_range(1, 3);
          for (int c = 0; c < curves; c++) begin
            if ($urandom_range(0, 7) == 0) len = $urandom_range(1, 3 * m);
            else len = 3 * m + 1 + $urandom_range(0, 24);
            send_curve(len, len);
          end
        end
      endcase
      drain();
      phase++;
    end

    repeat (50) @(posedge clk);
    if (failures == 0 && fits_pending.size() == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
